[rtl/jsu_pkg.sv]
// jsu_pkg: shared types, codes and character constants for the JSON string unescaper.
// Used by jsu_decoder, jsu_out_buffer and json_string_unescape. No dependencies.
package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2
    } jsu_mode_t;

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_END     = 2'd1,
        ST_BAD_ESC = 2'd2,
        ST_BAD_HEX = 2'd3
    } jsu_status_t;

    localparam int MaxResults = 3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    // Results of one input byte, first byte in slot 0
    typedef struct packed {
        logic [1:0]       count;
        jsu_status_t      status;
        logic [2:0][7:0]  bytes;
    } jsu_result_t;

    // Hex digit value; bit 4 set when the byte is no hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            v = {1'b0, b[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

[rtl/jsu_decoder.sv]
// jsu_decoder: escape-state registers and the one-pass decode of a raw byte.
// Depends on jsu_pkg.
module jsu_decoder import jsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  in_byte,
    output jsu_result_t res
);

    jsu_mode_t   mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] acc_reg, acc_next;

    always_comb begin
        logic [4:0]  d;
        logic [15:0] cp;
        d            = hex_value(in_byte);
        cp           = {acc_reg[11:0], d[3:0]};
        mode_next    = MODE_TEXT;
        hex_cnt_next = 2'd0;
        acc_next     = 16'd0;
        res.count    = 2'd0;
        res.status   = ST_DATA;
        res.bytes    = '0;
        case (mode_reg)
            MODE_ESC: begin
                res.count = 2'd1;
                case (in_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH: res.bytes[0] = in_byte;
                    CH_B: res.bytes[0] = CTL_BS;
                    CH_F: res.bytes[0] = CTL_FF;
                    CH_N: res.bytes[0] = CTL_LF;
                    CH_R: res.bytes[0] = CTL_CR;
                    CH_T: res.bytes[0] = CTL_HT;
                    CH_U: begin
                        res.count = 2'd0;
                        mode_next = MODE_HEX;
                    end
                    default: res.status = ST_BAD_ESC;
                endcase
            end
            MODE_HEX: begin
                if (d[4]) begin
                    res.count  = 2'd1;
                    res.status = ST_BAD_HEX;
                end else if (hex_cnt_reg != 2'd3) begin
                    mode_next    = MODE_HEX;
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    acc_next     = cp;
                end else if (cp[15:7] == 9'd0) begin
                    res.count    = 2'd1;
                    res.bytes[0] = cp[7:0];
                end else if (cp[15:11] == 5'd0) begin
                    res.count    = 2'd2;
                    res.bytes[0] = {3'b110, cp[10:6]};
                    res.bytes[1] = {2'b10, cp[5:0]};
                end else begin
                    res.count    = 2'd3;
                    res.bytes[0] = {4'b1110, cp[15:12]};
                    res.bytes[1] = {2'b10, cp[11:6]};
                    res.bytes[2] = {2'b10, cp[5:0]};
                end
            end
            default: begin
                if (in_byte == CH_QUOTE || in_byte == CH_NUL) begin
                    res.count  = 2'd1;
                    res.status = ST_END;
                end else if (in_byte == CH_BSL) begin
                    mode_next = MODE_ESC;
                end else begin
                    res.count    = 2'd1;
                    res.bytes[0] = in_byte;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_TEXT;
            hex_cnt_reg <= 2'd0;
            acc_reg     <= 16'd0;
        end else if (step) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            acc_reg     <= acc_next;
        end
    end

    // Digit count and accumulator live only inside a \u escape
    a_cnt_only_in_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_HEX |-> (hex_cnt_reg == 2'd0 && acc_reg == 16'd0))
        else $error("hex state left over outside a unicode escape");
    // Accumulator holds no more digits than were counted
    a_acc_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (hex_cnt_reg != 2'd1 || acc_reg[15:4] == 12'd0) &&
        (hex_cnt_reg != 2'd2 || acc_reg[15:8] == 8'd0))
        else $error("code point accumulator holds stray digits");
    // A result with a non-data code is always single
    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.status != ST_DATA |-> res.count == 2'd1)
        else $error("end or error result not single");

endmodule

[rtl/jsu_out_buffer.sv]
// jsu_out_buffer: result register for up to three bytes, drained one per cycle while m_ready is high.
// Depends on jsu_pkg.
module jsu_out_buffer import jsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  jsu_result_t res,
    output logic        can_load,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_status,
    output logic        m_last_of_run
);

    logic [2:0][7:0] data_reg;
    jsu_status_t     status_reg;
    logic [1:0]      cnt_reg, cnt_next;
    logic            pop;

    assign m_valid       = (cnt_reg != 2'd0);
    assign pop           = m_valid && m_ready;
    assign can_load      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign m_out_byte    = data_reg[0];
    assign m_status      = status_reg;
    assign m_last_of_run = (cnt_reg == 2'd1);

    always_comb begin
        cnt_next = cnt_reg;
        if (load && res.count != 2'd0) begin
            cnt_next = res.count;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload: load a fresh bundle or shift the next byte down
    always_ff @(posedge aclk) begin
        if (load && res.count != 2'd0) begin
            data_reg   <= res.bytes;
            status_reg <= res.status;
        end else if (pop) begin
            data_reg <= {8'd0, data_reg[2:1]};
        end
    end

    a_load_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("bundle loaded over undelivered results");
    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        load && res.count != 2'd0 |=> cnt_reg == $past(res.count))
        else $error("result count not taken from bundle");
    a_nondata_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && status_reg != ST_DATA |-> m_last_of_run)
        else $error("end or error result not last of its run");

endmodule

[rtl/json_string_unescape.sv]
// json_string_unescape: top level of the JSON string body unescaper.
// Depends on jsu_pkg, jsu_decoder and jsu_out_buffer.
//
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  input    | s_valid, s_ready, s_in_byte            | in
//  result   | m_valid, m_ready, m_out_byte,          | out
//           | m_status, m_last_of_run                |
//
// A raw byte is decoded in the cycle it is accepted and its results land in
// the result register at that edge; the first result is offered in the next cycle.
// Plain text moves one byte per cycle while m_ready is high. While a byte's results
// drain, one transaction per cycle with m_ready high, s_ready stays low until the last
// of them leaves, and the next byte is taken in that cycle. Bytes with no result
// (backslash, \u, the first three hex digits) only advance the parser. Reset (aresetn
// low, synchronous) returns the parser to text mode and empties the result register.
// A stall on m_ready backs up to s_ready directly.
module json_string_unescape import jsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_status,
    output logic        m_last_of_run
);

    jsu_result_t res;
    logic        load;

    // Advance the parser only on an accepted input transaction
    assign load = s_valid && s_ready;

    jsu_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (load),
        .in_byte (s_in_byte),
        .res     (res)
    );

    // Result register; ready while empty or while its last result leaves
    jsu_out_buffer u_out_buffer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .res           (res),
        .can_load      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench for json_string_unescape: directed and random JSON string bodies,
// with random idling on both channels and results checked against a built-in decoder.
// Depends on jsu_pkg and the json_string_unescape RTL.
`timescale 1ns / 100ps

module testbench;
    import jsu_pkg::*;

    // One queued input transaction, or a marker that makes the sender wait for all results
    typedef enum logic {RAW_BYTE, RAW_DRAIN} raw_kind_t;

    typedef struct {
        raw_kind_t  kind;
        logic [7:0] value;
        int         idle_after;
    } raw_item_t;

    // One expected result transaction
    typedef struct packed {
        logic [7:0]  data;
        jsu_status_t status;
        logic        last;
    } decoded_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_status;
    logic       m_last_of_run;

    raw_item_t  raw_bytes_q[$];
    decoded_t   decoded_q[$];
    decoded_t   want;

    // Decoder state mirrored from the block
    jsu_mode_t  mode_q = MODE_TEXT;
    logic [1:0] digits_q = 2'd0;
    logic [15:0] acc_q = 16'h0000;

    int fail_count = 0;
    int n_bytes = 0;
    int bytes_accepted = 0;
    int results_seen = 0;
    int idle_left = 0;
    int ready_wait = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit calm = 1'b0;

    json_string_unescape uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Idle length: mostly none, often a few cycles, now and then a long stretch
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Hex digit value in bits 3:0; bit 4 flags a byte that is no hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        if (b inside {[8'h30:8'h39]}) begin
            d = b - 8'h30;
        end else if (b inside {[8'h41:8'h46]}) begin
            d = b - 8'h37;
        end else if (b inside {[8'h61:8'h66]}) begin
            d = b - 8'h57;
        end else begin
            return 5'h10;
        end
        return {1'b0, d[3:0]};
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t ns: %s", $realtime, msg);
    endfunction

    // Advance the decoder by one accepted byte and queue the results it causes
    function automatic void unescape_byte(input logic [7:0] b);
        decoded_t    res [3];
        int          n;
        logic [4:0]  nib;
        logic [15:0] cp;
        n = 0;
        case (mode_q)
            MODE_ESC: begin
                mode_q = MODE_TEXT;
                digits_q = 2'd0;
                acc_q = 16'h0000;
                case (b)
                    CH_QUOTE, CH_BSL, CH_SLASH: begin
                        res[n] = '{data: b, status: ST_DATA, last: 1'b0};
                        n++;
                    end
                    CH_B: begin
                        res[n] = '{data: CTL_BS, status: ST_DATA, last: 1'b0};
                        n++;
                    end
                    CH_F: begin
                        res[n] = '{data: CTL_FF, status: ST_DATA, last: 1'b0};
                        n++;
                    end
                    CH_N: begin
                        res[n] = '{data: CTL_LF, status: ST_DATA, last: 1'b0};
                        n++;
                    end
                    CH_R: begin
                        res[n] = '{data: CTL_CR, status: ST_DATA, last: 1'b0};
                        n++;
                    end
                    CH_T: begin
                        res[n] = '{data: CTL_HT, status: ST_DATA, last: 1'b0};
                        n++;
                    end
                    CH_U: begin
                        mode_q = MODE_HEX;
                    end
                    default: begin
                        res[n] = '{data: 8'h00, status: ST_BAD_ESC, last: 1'b0};
                        n++;
                    end
                endcase
            end
            MODE_HEX: begin
                nib = hex_nibble(b);
                if (nib[4]) begin
                    // drop the partial code point
                    res[n] = '{data: 8'h00, status: ST_BAD_HEX, last: 1'b0};
                    n++;
                    mode_q = MODE_TEXT;
                    digits_q = 2'd0;
                    acc_q = 16'h0000;
                end else begin
                    acc_q = {acc_q[11:0], nib[3:0]};
                    if (digits_q != 2'd3) begin
                        digits_q = digits_q + 2'd1;
                    end else begin
                        cp = acc_q;
                        if (cp < 16'h0080) begin
                            res[n] = '{data: cp[7:0], status: ST_DATA, last: 1'b0};
                            n++;
                        end else if (cp < 16'h0800) begin
                            res[n] = '{data: {3'b110, cp[10:6]}, status: ST_DATA, last: 1'b0};
                            n++;
                            res[n] = '{data: {2'b10, cp[5:0]}, status: ST_DATA, last: 1'b0};
                            n++;
                        end else begin
                            res[n] = '{data: {4'b1110, cp[15:12]}, status: ST_DATA, last: 1'b0};
                            n++;
                            res[n] = '{data: {2'b10, cp[11:6]}, status: ST_DATA, last: 1'b0};
                            n++;
                            res[n] = '{data: {2'b10, cp[5:0]}, status: ST_DATA, last: 1'b0};
                            n++;
                        end
                        mode_q = MODE_TEXT;
                        digits_q = 2'd0;
                        acc_q = 16'h0000;
                    end
                end
            end
            default: begin
                if (b == CH_QUOTE || b == CH_NUL) begin
                    res[n] = '{data: 8'h00, status: ST_END, last: 1'b0};
                    n++;
                    mode_q = MODE_TEXT;
                    digits_q = 2'd0;
                    acc_q = 16'h0000;
                end else if (b == CH_BSL) begin
                    mode_q = MODE_ESC;
                    digits_q = 2'd0;
                    acc_q = 16'h0000;
                end else begin
                    res[n] = '{data: b, status: ST_DATA, last: 1'b0};
                    n++;
                end
            end
        endcase
        for (int i = 0; i < n; i++) begin
            res[i].last = (i == n - 1);
            decoded_q.push_back(res[i]);
        end
    endfunction

    // Stimulus building blocks
    task automatic push_raw(input logic [7:0] b);
        raw_bytes_q.push_back('{kind: RAW_BYTE, value: b, idle_after: calm ? 0 : pick_idle()});
        n_bytes++;
    endtask

    task automatic push_drain();
        raw_bytes_q.push_back('{kind: RAW_DRAIN, value: 8'h00, idle_after: 0});
    endtask

    // Hex digit of either case for letters
    task automatic push_hex_digit(input logic [3:0] v);
        if (v < 4'd10) begin
            push_raw(8'h30 + 8'(v));
        end else begin
            push_raw(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10);
        end
    endtask

    task automatic push_code_point(input logic [15:0] cp);
        push_raw(CH_BSL);
        push_raw(CH_U);
        push_hex_digit(cp[15:12]);
        push_hex_digit(cp[11:8]);
        push_hex_digit(cp[7:4]);
        push_hex_digit(cp[3:0]);
    endtask

    // Driver: present queued bytes, predict each one at the edge that accepts it
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            idle_left <= 0;
            mode_q = MODE_TEXT;
            digits_q = 2'd0;
            acc_q = 16'h0000;
        end else begin
            if (s_valid && s_ready) begin
                unescape_byte(s_in_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            // The slot is free when nothing is offered or the offer is taken now
            if (!s_valid || s_ready) begin
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                    s_valid <= 1'b0;
                end else if (raw_bytes_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (raw_bytes_q[0].kind == RAW_DRAIN) begin
                    // hold the sender until every expected result has left the block
                    s_valid <= 1'b0;
                    if (decoded_q.size() == 0) raw_bytes_q.delete(0);
                end else begin
                    s_valid <= 1'b1;
                    s_in_byte <= raw_bytes_q[0].value;
                    idle_left <= raw_bytes_q[0].idle_after;
                    raw_bytes_q.delete(0);
                end
            end
        end
    end

    // Receiver backpressure, with one long hold-off while the sender keeps offering
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_wait <= 0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && bytes_accepted >= 150) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            m_ready <= 1'b0;
        end else if (ready_wait > 0) begin
            ready_wait <= ready_wait - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            // stretches of results with no stall at all
            if (m_valid && m_ready && (results_seen % 300) >= 80) ready_wait <= pick_idle();
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (decoded_q.size() == 0) begin
                note_failure($sformatf("unexpected result: byte %02h status %0d last %0b",
                                       m_out_byte, m_status, m_last_of_run));
            end else begin
                want = decoded_q.pop_front();
                if (m_out_byte !== want.data || m_status !== want.status
                        || m_last_of_run !== want.last) begin
                    note_failure($sformatf(
                        "mismatch: expected byte %02h status %0d last %0b, got %02h %0d %0b",
                        want.data, want.status, want.last,
                        m_out_byte, m_status, m_last_of_run));
                end
            end
        end
    end

    // Safety net against a hung handshake
    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [7:0]  b;
        logic [4:0]  nib;
        logic [15:0] cp;
        int          pick;
        int          k;
        bit          drained_mid;

        drained_mid = 1'b0;

        // Directed part: field extremes, string ends, escapes, code point extremes, errors
        push_raw(8'h41);
        push_raw(8'hFF);
        push_raw(CH_QUOTE);
        push_raw(CH_NUL);
        push_raw(CH_BSL);
        push_raw(CH_T);
        push_raw(CH_BSL);
        push_raw(8'h78);
        push_raw(CH_BSL);
        push_raw(CH_NUL);
        push_code_point(16'h0000);
        push_code_point(16'hFFFF);
        push_raw(CH_BSL);
        push_raw(CH_U);
        push_raw(8'h37);
        push_raw(8'h67);
        push_drain();

        // Random part: mostly well-formed tokens with random content, plus noise
        while (n_bytes < 370) begin
            calm = ((n_bytes / 40) % 4 == 3);
            if (!drained_mid && n_bytes >= 250) begin
                push_drain();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                // plain text byte
                do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSL);
                push_raw(b);
            end else if (pick < 48) begin
                push_raw(CH_BSL);
                case ($urandom_range(0, 7))
                    0: push_raw(CH_QUOTE);
                    1: push_raw(CH_BSL);
                    2: push_raw(CH_SLASH);
                    3: push_raw(CH_B);
                    4: push_raw(CH_F);
                    5: push_raw(CH_N);
                    6: push_raw(CH_R);
                    default: push_raw(CH_T);
                endcase
            end else if (pick < 73) begin
                // one-, two- and three-byte encodings, surrogate halves included
                case ($urandom_range(0, 3))
                    0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    default: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                endcase
                push_code_point(cp);
            end else if (pick < 78) begin
                // unknown escape letter
                push_raw(CH_BSL);
                if ($urandom_range(0, 5) == 0) begin
                    b = CH_NUL;
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (b inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F,
                                     CH_N, CH_R, CH_T, CH_U});
                end
                push_raw(b);
            end else if (pick < 85) begin
                // broken \u sequence: some good digits, then a non-hex byte
                push_raw(CH_BSL);
                push_raw(CH_U);
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++) push_hex_digit(4'($urandom_range(0, 15)));
                if ($urandom_range(0, 3) == 0) begin
                    b = $urandom_range(0, 1) ? CH_QUOTE : CH_NUL;
                end else begin
                    do begin
                        b = 8'($urandom_range(0, 255));
                        nib = hex_nibble(b);
                    end while (!nib[4]);
                end
                push_raw(b);
            end else if (pick < 91) begin
                push_raw($urandom_range(0, 1) ? CH_QUOTE : CH_NUL);
            end else begin
                // noise: any byte at all
                push_raw(8'($urandom_range(0, 255)));
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the sender to run dry, then for the results to drain
        while (raw_bytes_q.size() != 0 || s_valid) @(posedge aclk);
        k = 0;
        while (decoded_q.size() != 0 && k < 20000) begin
            @(posedge aclk);
            k++;
        end
        repeat (20) @(posedge aclk);

        if (decoded_q.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived", decoded_q.size()));
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/jsu_pkg.sv
rtl/jsu_decoder.sv
rtl/jsu_out_buffer.sv
rtl/json_string_unescape.sv
tb/testbench.sv
